// File: design/pt_comp_pkg.sv
// ----------------------------------------------------------------------------
// pt_comp_pkg
// Types and constants shared by the pressure / temperature compensation block.
// ----------------------------------------------------------------------------
package pt_comp_pkg;

    localparam int DIV_BITS = 32;
    // depth from an accepted request to done, checked by the a_latency assertion
    localparam int LATENCY  = 14 + DIV_BITS;
    localparam int ADDR_W   = 5;

    typedef enum logic [1:0] {
        REG_TEMP_TRIM  = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_HIGH = 2'd2,
        REG_PRESS_LAST = 2'd3
    } reg_index_t;

    localparam logic [19:0] SKIP_CODE = 20'h80000;

    typedef struct packed {
        logic [19:0] temp_adc;
        logic [19:0] raw_press;
    } request_t;

    typedef struct packed {
        logic        reading_valid;
        logic [23:0] temp_centi;
        logic [31:0] press_pa;
    } result_t;

    // information that rides alongside the divider
    typedef struct packed {
        logic        ok;
        logic [23:0] tc;
        logic        mode;
        logic        zero;
    } div_side_t;

endpackage

// File: design/pt_comp_div.sv
// ----------------------------------------------------------------------------
// pt_comp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pt_comp_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [31:0]            num,
    input  logic [31:0]            den,
    input  pt_comp_pkg::div_side_t in_side,
    output logic                   out_valid,
    output logic [31:0]            quot,
    output pt_comp_pkg::div_side_t out_side
);
    import pt_comp_pkg::*;

    logic            vld_reg  [1:DIV_BITS];
    logic [31:0]     rem_reg  [1:DIV_BITS];
    logic [31:0]     num_reg  [1:DIV_BITS];
    logic [31:0]     den_reg  [1:DIV_BITS];
    div_side_t       side_reg [1:DIV_BITS];

    genvar k;
    generate
        for (k = 0; k < DIV_BITS; k++)
        begin : g_stage
            logic        vld_in;
            logic [31:0] rem_in;
            logic [31:0] num_in;
            logic [31:0] den_in;
            div_side_t   side_in;
            logic [32:0] trial;
            logic        fits;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = '0;
                assign num_in  = num;
                assign den_in  = den;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k];
                assign rem_in  = rem_reg[k];
                assign num_in  = num_reg[k];
                assign den_in  = den_reg[k];
                assign side_in = side_reg[k];
            end

            assign trial = {rem_in, num_in[31]};
            assign fits  = trial >= {1'b0, den_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k+1] <= 1'b0;
                else
                    vld_reg[k+1] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1]  <= fits ? 32'(trial - {1'b0, den_in}) : trial[31:0];
                num_reg[k+1]  <= {num_in[30:0], fits};
                den_reg[k+1]  <= den_in;
                side_reg[k+1] <= side_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_BITS];
    assign quot      = num_reg[DIV_BITS];
    assign out_side  = side_reg[DIV_BITS];

endmodule

// File: design/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric sensor compensation, 32-bit fixed point, fully pipelined.
//
// channel   | signals                                  | handshake
// ----------|------------------------------------------|----------------------
// request   | start, busy, request.temp_adc/raw_press  | start && !busy
// result    | done, result.*                           | done, one cycle
// config    | psel penable pwrite paddr pwdata prdata  | apb, pready tied high
//
// one request per cycle; busy is never raised
// the pipeline is the 32-stage divider plus 14 arithmetic stages
// reset clears the valid bits and all trim registers
// the receiver cannot stall, so no stage ever holds
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pt_comp_pkg::request_t              request,
    output logic                               done,
    output pt_comp_pkg::result_t               result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pt_comp_pkg::ADDR_W-1:0]     paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);
    import pt_comp_pkg::*;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // trim registers
    logic [47:0] temp_trim_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;
    reg_index_t  widx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_index_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg  <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_TEMP_TRIM:  temp_trim_reg  <= pwdata[47:0];
                REG_PRESS_LOW:  press_low_reg  <= pwdata;
                REG_PRESS_HIGH: press_high_reg <= pwdata;
                REG_PRESS_LAST: press_last_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_TEMP_TRIM:  prdata = {16'b0, temp_trim_reg};
            REG_PRESS_LOW:  prdata = press_low_reg;
            REG_PRESS_HIGH: prdata = press_high_reg;
            REG_PRESS_LAST: prdata = {48'b0, press_last_reg};
            default:        prdata = '0;
        endcase
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'b0, temp_trim_reg[15:0]};
    assign t2 = sx(temp_trim_reg[31:16]);
    assign t3 = sx(temp_trim_reg[47:32]);
    assign p1 = {16'b0, press_low_reg[15:0]};
    assign p2 = sx(press_low_reg[31:16]);
    assign p3 = sx(press_low_reg[47:32]);
    assign p4 = sx(press_low_reg[63:48]);
    assign p5 = sx(press_high_reg[15:0]);
    assign p6 = sx(press_high_reg[31:16]);
    assign p7 = sx(press_high_reg[47:32]);
    assign p8 = sx(press_high_reg[63:48]);
    assign p9 = sx(press_last_reg);

    // valid bits: stages 1..10, the divider input, and the l, m, n stages after the divider
    logic [10:1] v_reg;
    logic        v11_reg, vl_reg, vm_reg, vn_reg;

    // payload
    logic [19:0] rt1_reg;
    logic [31:0] rp_reg [1:9];
    logic        ok_reg [1:10];
    logic [31:0] ma2_reg, dd2_reg;
    logic [31:0] a3_reg, mb3_reg;
    logic [31:0] tf4_reg;
    logic [31:0] tcm5_reg, v15_reg;
    logic [23:0] tc_reg [6:10];
    logic [31:0] qq6_reg, m56_reg, m26_reg;
    logic [31:0] m67_reg, m37_reg, m57_reg, m27_reg;
    logic [31:0] v28_reg, x18_reg;
    logic [31:0] m19_reg, pn9_reg;
    logic [31:0] v1f10_reg, pm10_reg;
    logic [31:0] num11_reg, den11_reg;
    div_side_t   side11_reg;

    logic [31:0] x0, d0, q6;
    assign x0 = 32'(rt1_reg >> 3) - (t1 << 1);
    assign d0 = 32'(rt1_reg >> 4) - t1;
    assign q6 = asr(v15_reg, 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            v11_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= {v_reg[9:1], start && !busy};
            v11_reg <= v_reg[10];
        end
    end

    always_ff @(posedge clk)
    begin
        rt1_reg   <= request.temp_adc;
        rp_reg[1] <= {12'b0, request.raw_press};
        ok_reg[1] <= (request.temp_adc != SKIP_CODE) && (request.raw_press != SKIP_CODE);
        for (int i = 2; i <= 9; i++)
            rp_reg[i] <= rp_reg[i-1];
        for (int i = 2; i <= 10; i++)
            ok_reg[i] <= ok_reg[i-1];
        for (int i = 7; i <= 10; i++)
            tc_reg[i] <= tc_reg[i-1];

        ma2_reg  <= 32'(x0 * t2);
        dd2_reg  <= 32'(d0 * d0);
        a3_reg   <= asr(ma2_reg, 11);
        mb3_reg  <= 32'(asr(dd2_reg, 12) * t3);
        tf4_reg  <= a3_reg + asr(mb3_reg, 14);
        tcm5_reg <= 32'(tf4_reg * 32'd5);
        v15_reg  <= asr(tf4_reg, 1) - 32'd64000;

        qq6_reg   <= 32'(q6 * q6);
        m56_reg   <= 32'(v15_reg * p5);
        m26_reg   <= 32'(p2 * v15_reg);
        tc_reg[6] <= 24'(asr(tcm5_reg + 32'd128, 8));

        m67_reg <= 32'(asr(qq6_reg, 11) * p6);
        m37_reg <= 32'(p3 * asr(qq6_reg, 13));
        m57_reg <= m56_reg;
        m27_reg <= m26_reg;

        v28_reg <= asr(m67_reg + (m57_reg << 1), 2) + (p4 << 16);
        x18_reg <= asr(asr(m37_reg, 3) + asr(m27_reg, 1), 18);

        m19_reg <= 32'((32'd32768 + x18_reg) * p1);
        pn9_reg <= (32'd1048576 - rp_reg[8]) - asr(v28_reg, 12);

        v1f10_reg <= asr(m19_reg, 15);
        pm10_reg  <= 32'(pn9_reg * 32'd3125);

        num11_reg       <= pm10_reg[31] ? pm10_reg : (pm10_reg << 1);
        den11_reg       <= v1f10_reg;
        side11_reg.ok   <= ok_reg[10];
        side11_reg.tc   <= tc_reg[10];
        side11_reg.mode <= pm10_reg[31];
        side11_reg.zero <= v1f10_reg == 32'd0;
    end

    logic        dv;
    logic [31:0] dq;
    div_side_t   dside;

    pt_comp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v11_reg),
        .num      (num11_reg),
        .den      (den11_reg),
        .in_side  (side11_reg),
        .out_valid(dv),
        .quot     (dq),
        .out_side (dside)
    );

    logic [31:0] pd;
    assign pd = dside.mode ? (dq << 1) : dq;

    logic [31:0] pl_reg, mql_reg, m8l_reg, pm_reg, mvm_reg, v2m_reg;
    div_side_t   sl_reg, sm_reg;
    result_t     res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
        end
        else
        begin
            vl_reg <= dv;
            vm_reg <= vl_reg;
            vn_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg  <= pd;
        mql_reg <= 32'((pd >> 3) * (pd >> 3));
        m8l_reg <= 32'((pd >> 2) * p8);
        sl_reg  <= dside;

        pm_reg  <= pl_reg;
        mvm_reg <= 32'(p9 * (mql_reg >> 13));
        v2m_reg <= asr(m8l_reg, 13);
        sm_reg  <= sl_reg;

        if (!sm_reg.ok)
            res_reg <= '0;
        else
        begin
            res_reg.reading_valid <= 1'b1;
            res_reg.temp_centi    <= sm_reg.tc;
            res_reg.press_pa      <= sm_reg.zero ? 32'd0 :
                pm_reg + asr(asr(mvm_reg, 12) + v2m_reg + p7, 4);
        end
    end

    assign done   = vn_reg;
    assign result = res_reg;

    // every accepted request comes out as a done at the end of the full pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    // a skipped reading carries zero fields
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.reading_valid |-> result.press_pa == 32'd0 && result.temp_centi == 24'd0)
        else $error("skipped reading has nonzero fields");

    // the divider never shows valid without a request entering it earlier
    a_div_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dv |-> $past(v11_reg, DIV_BITS))
        else $error("divider valid without input");

endmodule

// File: sim/pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_tb
// Drives raw temperature / pressure pairs through the compensation pipeline
// under several trim settings, predicts each result with a local 32-bit
// integer model and compares every field of every result in order.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_tb;
    import pt_comp_pkg::*;

    localparam int N_RANDOM  = 700;
    localparam int WDOG_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // trim copies used by the predictor
    logic [47:0] trim_t;
    logic [63:0] trim_pl;
    logic [63:0] trim_ph;
    logic [15:0] trim_p9;

    result_t     pending_results[$];
    int          mismatches;
    int          n_requests;
    int          n_results;
    int          n_skipped;
    int          idle_cycles;

    pressure_temperature_compensation uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(logic [31:0] x, int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic result_t compensate(request_t rq);
        logic [31:0] t1, t2, t3, d, a, b, tf, tc;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] v1, v2, q, p, adc;
        result_t r;
        r = '0;
        if (rq.temp_adc == SKIP_CODE || rq.raw_press == SKIP_CODE)
            return r;
        adc = {12'd0, rq.temp_adc};
        t1 = {16'd0, trim_t[15:0]};
        t2 = sx16(trim_t[31:16]);
        t3 = sx16(trim_t[47:32]);
        a = sra(((adc >> 3) - (t1 << 1)) * t2, 11);
        d = (adc >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        tf = a + b;
        tc = sra(tf * 32'd5 + 32'd128, 8);
        r.reading_valid = 1'b1;
        r.temp_centi = tc[23:0];
        p1 = {16'd0, trim_pl[15:0]};
        p2 = sx16(trim_pl[31:16]);
        p3 = sx16(trim_pl[47:32]);
        p4 = sx16(trim_pl[63:48]);
        p5 = sx16(trim_ph[15:0]);
        p6 = sx16(trim_ph[31:16]);
        p7 = sx16(trim_ph[47:32]);
        p8 = sx16(trim_ph[63:48]);
        p9 = sx16(trim_p9);
        adc = {12'd0, rq.raw_press};
        v1 = sra(tf, 1) - 32'd64000;
        q = sra(v1, 2);
        v2 = sra(q * q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
        v1 = sra((32'd32768 + v1) * p1, 15);
        if (v1 == 32'd0)
        begin
            r.press_pa = 32'd0;
            return r;
        end
        p = ((32'd1048576 - adc) - sra(v2, 12)) * 32'd3125;
        if (p < 32'h8000_0000)
            p = (p << 1) / v1;
        else
            p = (p / v1) * 32'd2;
        v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        v2 = sra((p >> 2) * p8, 13);
        r.press_pa = p + sra(v1 + v2 + p7, 4);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
                report("unexpected result", 32'(result.press_pa), 32'd0);
            else
            begin
                result_t w;
                w = pending_results.pop_front();
                if (result.reading_valid !== w.reading_valid)
                    report("reading_valid", 32'(result.reading_valid), 32'(w.reading_valid));
                if (result.temp_centi !== w.temp_centi)
                    report("temp_centi", 32'(result.temp_centi), 32'(w.temp_centi));
                if (result.press_pa !== w.press_pa)
                    report("press_pa", result.press_pa, w.press_pa);
            end
        end
    end

    // watchdog on cycles with results pending but nothing accepted or returned
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n || pending_results.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP_TRIM:  trim_t = value[47:0];
            REG_PRESS_LOW:  trim_pl = value;
            REG_PRESS_HIGH: trim_ph = value;
            REG_PRESS_LAST: trim_p9 = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_trims(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                              logic [15:0] p9);
        write_reg(REG_TEMP_TRIM, {16'd0, t});
        write_reg(REG_PRESS_LOW, pl);
        write_reg(REG_PRESS_HIGH, ph);
        write_reg(REG_PRESS_LAST, {48'd0, p9});
    endtask

    // hands one request to the block; start stays high across back-to-back calls when hold is set
    task automatic send(request_t rq, logic hold);
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(compensate(rq));
        n_requests++;
        if (rq.temp_adc == SKIP_CODE || rq.raw_press == SKIP_CODE)
            n_skipped++;
        if (!hold)
            start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    function automatic logic [19:0] rand_raw();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return SKIP_CODE;
        if (sel == 1)
            return 20'h00000;
        if (sel == 2)
            return 20'hFFFFF;
        if (sel < 12)
            return 20'($urandom_range(300000, 700000));
        return 20'($urandom);
    endfunction

    // directed table: raw pair and, where obvious, the expected result
    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        logic        typed;
        result_t     want;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{20'h00000, 20'h00000, 1'b1, '{1'b1, 24'd0, 32'd0}},
        '{20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b1, 24'd0, 32'd0}},
        '{SKIP_CODE, 20'h12345, 1'b1, '{1'b0, 24'd0, 32'd0}},
        '{20'h12345, SKIP_CODE, 1'b1, '{1'b0, 24'd0, 32'd0}},
        '{SKIP_CODE, SKIP_CODE, 1'b1, '{1'b0, 24'd0, 32'd0}},
        '{20'h7FFFF, 20'h80001, 1'b0, '0},
        '{20'h80001, 20'h7FFFF, 1'b0, '0},
        '{20'd519888, 20'd415148, 1'b0, '0},
        '{20'h00000, 20'hFFFFF, 1'b0, '0},
        '{20'hFFFFF, 20'h00000, 1'b0, '0},
        '{20'h55555, 20'hAAAAA, 1'b0, '0},
        '{20'hAAAAA, 20'h55555, 1'b0, '0},
        '{SKIP_CODE, 20'h00000, 1'b0, '0}
    };

    // zero trims make every valid reading come out as zero
    task automatic run_table(logic zero_trims);
        result_t w;
        foreach (dir_rows[i])
        begin
            w = compensate('{dir_rows[i].rt, dir_rows[i].rp});
            if (dir_rows[i].typed && (zero_trims || !dir_rows[i].want.reading_valid) &&
                w !== dir_rows[i].want)
                report("table row", 32'(i), 32'(w.press_pa));
            send('{dir_rows[i].rt, dir_rows[i].rp}, i != dir_rows.size() - 1);
        end
        drain();
    endtask

    task automatic run_random(int count);
        int   sent;
        int   burst;
        int   gap;
        logic pause;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            pause = ($urandom_range(0, 30) == 0);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                // keep start high into the next burst when no idle follows
                send('{rand_raw(), rand_raw()},
                     (sent != count - 1) && (k != burst - 1 || (gap == 0 && !pause)));
                sent++;
            end
            if (gap > 0)
                repeat (gap)
                    @(posedge clk);
            if (pause)
                while (pending_results.size() != 0)
                    @(posedge clk);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        trim_t = '0;
        trim_pl = '0;
        trim_ph = '0;
        trim_p9 = '0;
        mismatches = 0;
        n_requests = 0;
        n_results = 0;
        n_skipped = 0;
        idle_cycles = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset trims: divisor is zero, so pressure reads zero
        run_table(1'b1);

        // typical factory trims
        load_trims({16'hFC18, 16'h6A5C, 16'h6E2F},
                   {16'hFFF9, 16'hD0B6, 16'hD5A4, 16'h8EAA},
                   {16'hE5B1, 16'h3C70, 16'hFFF9, 16'h008C}, 16'h1770);
        run_table(1'b0);
        run_random(N_RANDOM / 2);

        // extremes of the trims
        load_trims(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        run_random(40);
        load_trims({16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
        run_random(40);
        load_trims({16'h7FFF, 16'h8000, 16'h0000},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
                   {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF);
        run_random(40);

        // random trims
        repeat (4)
        begin
            load_trims({16'($urandom), 32'($urandom)},
                       {32'($urandom), 32'($urandom)},
                       {32'($urandom), 32'($urandom)}, 16'($urandom));
            run_random(N_RANDOM / 12);
        end

        $display("%0d requests (%0d skipped), %0d results checked under 9 trim sets",
                 n_requests, n_skipped, n_results);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
